### rtl/core/mhwdg_pkg.sv
package mhwdg_pkg;

	// fixed field widths
	localparam int CHAN_W = 4;
	localparam int TAG_W  = 6;
	localparam int LVL_W  = 2;

	// item kinds
	localparam logic ACT_CONFIG = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// level codes, anything that is neither low nor high behaves as unknown
	localparam logic [LVL_W-1:0] LVL_LOW     = 2'd0;
	localparam logic [LVL_W-1:0] LVL_HIGH    = 2'd1;
	localparam logic [LVL_W-1:0] LVL_UNKNOWN = 2'd2;

	// decision handed from the evaluator to the pipeline control
	typedef struct packed {
		logic             write;
		logic             emit;
		logic [LVL_W-1:0] level;
	} mhwdg_ctl_t;

endpackage

### rtl/core/mhwdg_item_if.sv
interface mhwdg_item_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic [mhwdg_pkg::CHAN_W-1:0]      channel;
	logic [SAMPLE_BITS-1:0]            sample;
	logic [SAMPLE_BITS-1:0]            threshold;
	logic [SAMPLE_BITS-1:0]            upper_margin;
	logic [SAMPLE_BITS-1:0]            lower_margin;
	logic [mhwdg_pkg::TAG_W-1:0]       pin_tag;
	logic [mhwdg_pkg::LVL_W-1:0]       initial_level;
	logic                              enable;

	modport source (
		output valid, action, channel, sample, threshold, upper_margin, lower_margin,
		       pin_tag, initial_level, enable,
		input  ready
	);
	modport sink (
		input  valid, action, channel, sample, threshold, upper_margin, lower_margin,
		       pin_tag, initial_level, enable,
		output ready
	);
endinterface

### rtl/core/mhwdg_notice_if.sv
interface mhwdg_notice_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                         valid;
	logic                         ready;
	logic [mhwdg_pkg::TAG_W-1:0]  notify_pin;
	logic [SAMPLE_BITS-1:0]       notify_sample;
	logic                         new_level;

	modport source (
		output valid, notify_pin, notify_sample, new_level,
		input  ready
	);
	modport sink (
		input  valid, notify_pin, notify_sample, new_level,
		output ready
	);
endinterface

### rtl/core/mhwdg_table.sv
module mhwdg_table #(
	parameter int CHANNELS    = 16,
	parameter int SAMPLE_BITS = 10,
	parameter int IDX_W       = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [IDX_W-1:0]                  rd_addr,
	input  logic                              wr_en,
	input  logic [IDX_W-1:0]                  wr_addr,
	input  logic [SAMPLE_BITS-1:0]            wr_threshold,
	input  logic [SAMPLE_BITS-1:0]            wr_upper,
	input  logic [SAMPLE_BITS-1:0]            wr_lower,
	input  logic [mhwdg_pkg::TAG_W-1:0]       wr_tag,
	input  logic [mhwdg_pkg::LVL_W-1:0]       wr_level,
	input  logic                              wr_enable,
	output logic [SAMPLE_BITS-1:0]            rd_threshold,
	output logic [SAMPLE_BITS-1:0]            rd_upper,
	output logic [SAMPLE_BITS-1:0]            rd_lower,
	output logic [mhwdg_pkg::TAG_W-1:0]       rd_tag,
	output logic [mhwdg_pkg::LVL_W-1:0]       rd_level,
	output logic                              rd_enable
);
	import mhwdg_pkg::*;

	localparam int ENTRY_W = 3 * SAMPLE_BITS + TAG_W + LVL_W;

	logic [ENTRY_W-1:0] mem [CHANNELS];
	logic [CHANNELS-1:0] enable_q;
	logic [ENTRY_W-1:0] wr_entry;
	logic [ENTRY_W-1:0] rd_entry_q;
	logic               rd_enable_q;
	logic               fwd;

	assign wr_entry = {wr_threshold, wr_upper, wr_lower, wr_tag, wr_level};
	// a write in the same cycle to the address being read wins
	assign fwd      = wr_en && (wr_addr == rd_addr);

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= fwd ? wr_entry : mem[rd_addr];
		end
	end

	// enable bits double as entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= '0;
			rd_enable_q <= 1'b0;
		end else begin
			if (wr_en) begin
				enable_q[wr_addr] <= wr_enable;
			end
			if (rd_en) begin
				rd_enable_q <= fwd ? wr_enable : enable_q[rd_addr];
			end
		end
	end

	assign {rd_threshold, rd_upper, rd_lower, rd_tag, rd_level} = rd_entry_q;
	assign rd_enable = rd_enable_q;

	// a write with enable low leaves the entry disabled
	a_no_write_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !wr_enable) |=> !enable_q[$past(wr_addr)])
		else $error("enable bit not cleared by write");
	a_fwd_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && fwd) |=> (rd_enable == $past(wr_enable)))
		else $error("forwarded enable lost");
	a_fwd_level: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && fwd) |=> (rd_level == $past(wr_level)))
		else $error("forwarded level lost");

endmodule

### rtl/core/mhwdg_eval.sv
module mhwdg_eval #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                              action,
	input  logic                              in_range,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic [SAMPLE_BITS-1:0]            threshold,
	input  logic [SAMPLE_BITS-1:0]            upper_margin,
	input  logic [SAMPLE_BITS-1:0]            lower_margin,
	input  logic [mhwdg_pkg::LVL_W-1:0]       level,
	input  logic                              enable,
	input  logic [mhwdg_pkg::LVL_W-1:0]       initial_level,
	output mhwdg_pkg::mhwdg_ctl_t             ctl
);
	import mhwdg_pkg::*;

	logic [SAMPLE_BITS:0] smp_plus_lo;
	logic [SAMPLE_BITS:0] thr_plus_up;
	logic                 fall;
	logic                 rise;
	logic [LVL_W-1:0]     next_level;
	logic                 is_cfg;
	logic                 emit;

	// compare in one extra bit so neither side can wrap
	assign smp_plus_lo = {1'b0, sample} + {1'b0, lower_margin};
	assign thr_plus_up = {1'b0, threshold} + {1'b0, upper_margin};
	assign fall = (level != LVL_LOW) && (smp_plus_lo <= {1'b0, threshold});
	assign rise = (level != LVL_HIGH) && ({1'b0, sample} >= thr_plus_up);

	// rising test wins when both hold
	always_comb begin
		next_level = level;
		if (fall) begin
			next_level = LVL_LOW;
		end
		if (rise) begin
			next_level = LVL_HIGH;
		end
	end

	assign is_cfg = (action == ACT_CONFIG);
	assign emit   = in_range && !is_cfg && enable && (next_level != level);

	assign ctl.emit  = emit;
	assign ctl.write = in_range && (is_cfg || emit);
	assign ctl.level = is_cfg ? initial_level : next_level;

endmodule

### rtl/core/multichannel_hysteresis_watchdog_top.sv
// Multichannel analog watchdog with per-channel hysteresis.
// Channel "item" (sink) takes two kinds of transfer: a configure item that
// writes a whole channel entry (threshold, margins, pin tag, level, enable)
// and a sample item that is checked against the addressed channel.
// Channel "notice" (source) carries one result when an enabled channel's
// level flips to low or high: the pin tag, the sample and the new level.
// Items to channels beyond the table are dropped.
// A sample's table read is registered on acceptance; decision, table
// write-back and notice register load happen as it leaves the first stage.
// Throughput: one item per cycle unless a notice stall holds the stage, set
// by the entry memory's separate read and write ports with same-cycle write
// forwarding; back-to-back items to one channel see the prior item's write.
// Reset clears all enables, so every channel is disabled until configured.
// When the receiver stalls with a notice pending, items that produce no
// notice still flow; one that would notify waits in the first stage and
// item.ready drops until the notice register empties.
module multichannel_hysteresis_watchdog_top #(
	parameter int CHANNELS    = 16,
	parameter int SAMPLE_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	mhwdg_item_if.sink    item,
	mhwdg_notice_if.source notice
);
	import mhwdg_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// first stage: accepted item, table read happens alongside
	logic                   valid_s1;
	logic                   action_s1;
	logic [CHAN_W-1:0]      chan_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] threshold_s1;
	logic [SAMPLE_BITS-1:0] upper_s1;
	logic [SAMPLE_BITS-1:0] lower_s1;
	logic [TAG_W-1:0]       tag_s1;
	logic [LVL_W-1:0]       init_level_s1;
	logic                   enable_s1;

	logic [SAMPLE_BITS-1:0] rd_threshold;
	logic [SAMPLE_BITS-1:0] rd_upper;
	logic [SAMPLE_BITS-1:0] rd_lower;
	logic [TAG_W-1:0]       rd_tag;
	logic [LVL_W-1:0]       rd_level;
	logic                   rd_enable;

	logic                   out_valid_q;
	logic [TAG_W-1:0]       out_pin_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic                   out_level_q;

	mhwdg_ctl_t             ctl;
	logic                   in_range_s1;
	logic                   is_cfg_s1;
	logic                   out_free;
	logic                   fire;
	logic                   accept;
	logic                   wr_en;

	assign in_range_s1 = (32'(chan_s1) < CHANNELS);
	assign is_cfg_s1   = (action_s1 == ACT_CONFIG);

	// handshake control
	assign out_free   = !out_valid_q || notice.ready;
	assign fire       = valid_s1 && (!ctl.emit || out_free);
	assign item.ready = !valid_s1 || fire;
	assign accept     = item.valid && item.ready;
	assign wr_en      = fire && ctl.write;

	// entry table
	mhwdg_table #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IDX_W       (IDX_W)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (accept),
		.rd_addr      (IDX_W'(item.channel)),
		.wr_en        (wr_en),
		.wr_addr      (IDX_W'(chan_s1)),
		.wr_threshold (is_cfg_s1 ? threshold_s1 : rd_threshold),
		.wr_upper     (is_cfg_s1 ? upper_s1 : rd_upper),
		.wr_lower     (is_cfg_s1 ? lower_s1 : rd_lower),
		.wr_tag       (is_cfg_s1 ? tag_s1 : rd_tag),
		.wr_level     (ctl.level),
		.wr_enable    (is_cfg_s1 ? enable_s1 : rd_enable),
		.rd_threshold (rd_threshold),
		.rd_upper     (rd_upper),
		.rd_lower     (rd_lower),
		.rd_tag       (rd_tag),
		.rd_level     (rd_level),
		.rd_enable    (rd_enable)
	);

	// hysteresis decision
	mhwdg_eval #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_eval (
		.action        (action_s1),
		.in_range      (in_range_s1),
		.sample        (sample_s1),
		.threshold     (rd_threshold),
		.upper_margin  (rd_upper),
		.lower_margin  (rd_lower),
		.level         (rd_level),
		.enable        (rd_enable),
		.initial_level (init_level_s1),
		.ctl           (ctl)
	);

	// first stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// first stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1     <= item.action;
			chan_s1       <= item.channel;
			sample_s1     <= item.sample;
			threshold_s1  <= item.threshold;
			upper_s1      <= item.upper_margin;
			lower_s1      <= item.lower_margin;
			tag_s1        <= item.pin_tag;
			init_level_s1 <= item.initial_level;
			enable_s1     <= item.enable;
		end
	end

	// notice register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (notice.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// notice register payload
	always_ff @(posedge clk) begin
		if (fire && ctl.emit) begin
			out_pin_q    <= rd_tag;
			out_sample_q <= sample_s1;
			out_level_q  <= ctl.level[0];
		end
	end

	assign notice.valid         = out_valid_q;
	assign notice.notify_pin    = out_pin_q;
	assign notice.notify_sample = out_sample_q;
	assign notice.new_level     = out_level_q;

	// a notice only ever follows a sample item
	a_notice_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl.emit) |-> (action_s1 == ACT_SAMPLE))
		else $error("notice from a configure item");
	// a held first stage blocks new transfers
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |-> !item.ready)
		else $error("item accepted over a stalled stage");
	// no notice is overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !notice.ready) |-> !(fire && ctl.emit))
		else $error("pending notice overwritten");
	// table is written only by an item leaving the first stage
	a_write_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (valid_s1 && in_range_s1))
		else $error("table write without an item");

endmodule
